// ===== rtl/core/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and codes of the fixed block pool allocator
// Beat payload structs, operation codes, register indexes and the control
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  // field widths fixed by the interface
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int CNT_W   = 7;
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 8;
  localparam int CDATA_W = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_POOL_BASE   = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_SIZE  = 8'd1;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT = 8'd2;

  // register reset values
  localparam logic [ADDR_W-1:0] POOL_BASE_RST   = 32'd1;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd1;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 7'd64;

  // last step of the bit-serial divider (one quotient bit per step)
  localparam logic [4:0] DIV_LAST = 5'd31;

  // status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
  } fbpa_in_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
  } fbpa_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DIV_CHK,
    S_FREE_CHK,
    S_REPORT
  } fbpa_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: bitmap based fixed-size block pool allocator
// An allocate checks one map bit per cycle for the lowest free block; a free
// runs a 32-step bit-serial divider, a range check on the block index and a
// map check; a zero or low address and an unknown code go straight to the
// result beat; a clear sweeps the map RAM. A command is taken only while busy is low.
// Result strobe cannot be stalled; after reset a clearing pass runs with busy
// high; config writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command beat
  input  wire logic                  start,
  output logic                       busy,
  input  wire fbpa_pkg::fbpa_in_t    in_data,
  // result beat
  output logic                       out_valid,
  output fbpa_pkg::fbpa_out_t        out_data,
  // configuration write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [fbpa_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [fbpa_pkg::CDATA_W-1:0] cfg_data
);

  localparam int ADDR_W = fbpa_pkg::ADDR_W;
  localparam int SIZE_W = fbpa_pkg::SIZE_W;
  localparam int CNT_W  = fbpa_pkg::CNT_W;
  localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NW     = $clog2(MAX_BLOCKS + 1);
  localparam int CW     = (NW > CNT_W) ? NW : CNT_W;
  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_BLOCKS - 1);

  // configuration registers
  logic [ADDR_W-1:0] pool_base_r;
  logic [SIZE_W-1:0] block_size_r;
  logic [CNT_W-1:0]  block_count_r;

  // control and datapath registers
  fbpa_pkg::fbpa_state_t state_r, state_nxt;
  logic              clr_op_r, clr_op_nxt;
  logic [NW-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0] acc_r, acc_nxt;
  logic [ADDR_W-1:0] dvd_r, dvd_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [4:0]        bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic              status_r, status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  fbpa_pkg::fbpa_out_t out_r, out_nxt;

  // map RAM signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  // derived values
  logic [SIZE_W-1:0] size_w;
  logic [NW-1:0]     n_w;
  logic [CW-1:0]     bc_ext;
  logic [CW-1:0]     n_ext;
  logic [CW-1:0]     taken_ext;
  logic [CNT_W-1:0]  free_w;
  logic [SIZE_W:0]   trial_w;
  logic [SIZE_W:0]   diff_w;
  logic              q_bit;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= fbpa_pkg::POOL_BASE_RST;
      block_size_r  <= fbpa_pkg::BLOCK_SIZE_RST;
      block_count_r <= fbpa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fbpa_pkg::CFG_POOL_BASE:   pool_base_r   <= cfg_data[ADDR_W-1:0];
        fbpa_pkg::CFG_BLOCK_SIZE:  block_size_r  <= cfg_data[SIZE_W-1:0];
        fbpa_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero block size acts as one, block count held to capacity
  assign size_w = (block_size_r == '0) ? SIZE_W'(1) : block_size_r;
  assign bc_ext = CW'(block_count_r);
  assign n_w    = (bc_ext >= CW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(bc_ext);

  // free count floored at zero
  assign n_ext     = CW'(n_w);
  assign taken_ext = CW'(taken_r);
  assign free_w    = (n_ext > taken_ext) ? CNT_W'(n_ext - taken_ext) : '0;

  // one restoring divide step
  assign trial_w = {rem_r, dvd_r[ADDR_W-1]};
  assign diff_w  = trial_w - {1'b0, size_w};
  assign q_bit   = ~diff_w[SIZE_W];

  // map RAM, read address is the next index so read data is for the checked index
  fbpa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::S_CLEAR;
      clr_op_r    <= 1'b0;
      idx_r       <= '0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_op_r    <= clr_op_nxt;
      idx_r       <= idx_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    status_r   <= status_nxt;
    res_addr_r <= res_addr_nxt;
    out_r      <= out_nxt;
  end

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    clr_op_nxt    = clr_op_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    taken_nxt     = taken_r;
    status_nxt    = status_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = 1'b0;

    unique case (state_r)
      // sweep zeros through the map
      fbpa_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          taken_nxt = '0;
          if (clr_op_r) begin
            status_nxt   = fbpa_pkg::ST_OK;
            res_addr_nxt = '0;
            state_nxt    = fbpa_pkg::S_REPORT;
          end else begin
            state_nxt = fbpa_pkg::S_IDLE;
          end
          clr_op_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + NW'(1);
        end
      end

      // take a command beat
      fbpa_pkg::S_IDLE: begin
        if (start) begin
          status_nxt   = fbpa_pkg::ST_ERR;
          res_addr_nxt = '0;
          unique case (in_data.operation)
            fbpa_pkg::OP_ALLOC: begin
              idx_nxt   = '0;
              acc_nxt   = pool_base_r;
              state_nxt = fbpa_pkg::S_SCAN;
            end
            fbpa_pkg::OP_FREE: begin
              if (in_data.address == '0 || in_data.address < pool_base_r) begin
                state_nxt = fbpa_pkg::S_REPORT;
              end else begin
                dvd_nxt     = in_data.address - pool_base_r;
                rem_nxt     = '0;
                bit_cnt_nxt = '0;
                state_nxt   = fbpa_pkg::S_DIV;
              end
            end
            fbpa_pkg::OP_CLEAR: begin
              idx_nxt    = '0;
              clr_op_nxt = 1'b1;
              state_nxt  = fbpa_pkg::S_CLEAR;
            end
            default: begin
              state_nxt = fbpa_pkg::S_REPORT;
            end
          endcase
        end
      end

      // check one map bit per cycle for the lowest free block
      fbpa_pkg::S_SCAN: begin
        if (idx_r >= n_w) begin
          state_nxt = fbpa_pkg::S_REPORT;
        end else if (!ram_rdata) begin
          ram_we       = 1'b1;
          ram_wdata    = 1'b1;
          taken_nxt    = taken_r + CNT_W'(1);
          status_nxt   = fbpa_pkg::ST_OK;
          res_addr_nxt = acc_r;
          state_nxt    = fbpa_pkg::S_REPORT;
        end else begin
          idx_nxt = idx_r + NW'(1);
          acc_nxt = acc_r + ADDR_W'(size_w);
        end
      end

      // offset divided by block size, one quotient bit per cycle
      fbpa_pkg::S_DIV: begin
        dvd_nxt = {dvd_r[ADDR_W-2:0], q_bit};
        rem_nxt = q_bit ? diff_w[SIZE_W-1:0] : trial_w[SIZE_W-1:0];
        if (bit_cnt_r == fbpa_pkg::DIV_LAST) begin
          state_nxt = fbpa_pkg::S_DIV_CHK;
        end else begin
          bit_cnt_nxt = bit_cnt_r + 5'd1;
        end
      end

      // range check on the block index, then read its mark
      fbpa_pkg::S_DIV_CHK: begin
        if (dvd_r < ADDR_W'(n_w)) begin
          idx_nxt   = NW'(dvd_r);
          state_nxt = fbpa_pkg::S_FREE_CHK;
        end else begin
          state_nxt = fbpa_pkg::S_REPORT;
        end
      end

      // clear the mark of a taken block
      fbpa_pkg::S_FREE_CHK: begin
        if (ram_rdata) begin
          ram_we     = 1'b1;
          ram_wdata  = 1'b0;
          taken_nxt  = (taken_r != '0) ? taken_r - CNT_W'(1) : taken_r;
          status_nxt = fbpa_pkg::ST_OK;
        end
        state_nxt = fbpa_pkg::S_REPORT;
      end

      // load the result beat
      fbpa_pkg::S_REPORT: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = status_r;
        out_nxt.block_address = res_addr_r;
        out_nxt.free_count    = free_w;
        out_nxt.used_count    = taken_r;
        state_nxt             = fbpa_pkg::S_IDLE;
      end

      default: begin
        state_nxt = fbpa_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  assign busy      = (state_r != fbpa_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== sim/tb_fixed_block_pool_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator: self-checking bench of the block pool allocator
// Directed allocate, free, clear and unknown-operation commands, register edge
// cases (zero size, zero and oversized count, shrink with live blocks, address
// wrap, stray register index), then random pool traffic under several register
// settings and sender idle rates. Results are checked against a built-in pool
// model.
// ----------------------------------------------------------------------------

module tb_fixed_block_pool_allocator;

  localparam int ADDR_W  = fbpa_pkg::ADDR_W;
  localparam int SIZE_W  = fbpa_pkg::SIZE_W;
  localparam int CNT_W   = fbpa_pkg::CNT_W;
  localparam int OP_W    = fbpa_pkg::OP_W;
  localparam int CIDX_W  = fbpa_pkg::CIDX_W;
  localparam int CDATA_W = fbpa_pkg::CDATA_W;

  localparam int POOL_MAX = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 125;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  fbpa_pkg::fbpa_in_t in_data;
  logic out_valid;
  fbpa_pkg::fbpa_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  // pool model state
  logic [ADDR_W-1:0] m_base;
  logic [SIZE_W-1:0] m_size;
  logic [CNT_W-1:0] m_count;
  logic [POOL_MAX-1:0] m_taken;
  int unsigned m_taken_total;

  fbpa_pkg::fbpa_out_t pending_results[$];
  int unsigned sender_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(POOL_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned blocks_active();
    return (m_count > POOL_MAX) ? POOL_MAX : int'(m_count);
  endfunction

  function automatic int unsigned block_bytes();
    return (m_size == 0) ? 1 : int'(m_size);
  endfunction

  // register write as seen by the pool
  function automatic void apply_reg(input logic [CIDX_W-1:0] idx,
                                    input logic [CDATA_W-1:0] data);
    case (idx)
      fbpa_pkg::CFG_POOL_BASE: m_base = data;
      fbpa_pkg::CFG_BLOCK_SIZE: m_size = data[SIZE_W-1:0];
      fbpa_pkg::CFG_BLOCK_COUNT: m_count = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // pool response to one command, updating the model map
  function automatic fbpa_pkg::fbpa_out_t predict_pool_result(input fbpa_pkg::fbpa_in_t cmd);
    fbpa_pkg::fbpa_out_t r;
    int unsigned n;
    logic [31:0] sz;
    logic [31:0] idx;
    logic found;
    n = blocks_active();
    sz = block_bytes();
    r = '0;
    r.status = fbpa_pkg::ST_ERR;
    found = 1'b0;
    case (cmd.operation)
      fbpa_pkg::OP_ALLOC: begin
        for (int unsigned i = 0; i < n; i++) begin
          if (!found && !m_taken[i]) begin
            found = 1'b1;
            m_taken[i] = 1'b1;
            m_taken_total++;
            idx = i;
            r.block_address = m_base + idx * sz;
            r.status = fbpa_pkg::ST_OK;
          end
        end
      end
      fbpa_pkg::OP_FREE: begin
        if (cmd.address != 0 && cmd.address >= m_base) begin
          idx = (cmd.address - m_base) / sz;
          if (idx < n) begin
            if (m_taken[idx]) begin
              m_taken[idx] = 1'b0;
              if (m_taken_total > 0) m_taken_total--;
              r.status = fbpa_pkg::ST_OK;
            end
          end
        end
      end
      fbpa_pkg::OP_CLEAR: begin
        m_taken = '0;
        m_taken_total = 0;
        r.status = fbpa_pkg::ST_OK;
      end
      default: ;
    endcase
    r.free_count = (n > m_taken_total) ? CNT_W'(n - m_taken_total) : '0;
    r.used_count = CNT_W'(m_taken_total);
    return r;
  endfunction

  // result check, one beat per strobe
  always @(posedge clk) begin : result_check
    fbpa_pkg::fbpa_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.block_address, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.block_address !== want.block_address)
          report_mismatch("block_address", out_data.block_address, want.block_address);
        if (out_data.free_count !== want.free_count)
          report_mismatch("free_count", 32'(out_data.free_count), 32'(want.free_count));
        if (out_data.used_count !== want.used_count)
          report_mismatch("used_count", 32'(out_data.used_count), 32'(want.used_count));
      end
    end
  end

  // one command beat; start stays high after acceptance
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    fbpa_pkg::fbpa_in_t cmd;
    int unsigned gap;
    cmd.operation = op;
    cmd.address = addr;
    gap = 0;
    if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct)
      gap = $urandom_range(1, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_pool_result(cmd));
  endtask

  // stop commands and let every pending result come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                          input logic [CNT_W-1:0] count);
    wait_idle();
    write_reg(fbpa_pkg::CFG_POOL_BASE, base, 1'b0);
    write_reg(fbpa_pkg::CFG_BLOCK_SIZE, CDATA_W'(size), 1'b0);
    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, CDATA_W'(count), 1'b1);
  endtask

  // registers at their reset values
  task automatic test_reset_defaults();
    send_cmd(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    send_cmd(fbpa_pkg::OP_FREE, 32'd1);
  endtask

  // every operation and every free error on a four block pool
  task automatic test_basic_ops();
    set_pool(32'h0000_1000, 16'h0010, 7'd4);
    send_cmd(fbpa_pkg::OP_CLEAR, '0);
    repeat (4) send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);              // pool exhausted
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_1010);
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_1010);    // already free
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_1027);    // unaligned inside block 2
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_0000);    // zero address
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_0FFF);    // below base
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_1040);    // index past count
    send_cmd(fbpa_pkg::OP_NONE, 32'hFFFF_FFFF);
    send_cmd(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);    // huge index
  endtask

  // register corner cases, map kept across writes
  task automatic test_register_edges();
    // shrink below live blocks
    wait_idle();
    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'd2, 1'b1);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_1030);
    // zero block count
    wait_idle();
    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'd0, 1'b1);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    // count above capacity
    wait_idle();
    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'd127, 1'b1);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_1030);
    // zero size behaves as one byte
    set_pool(32'h0000_0010, 16'h0000, 7'd64);
    send_cmd(fbpa_pkg::OP_CLEAR, '0);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_FREE, 32'h0000_0011);
    // writes past the register set are dropped
    wait_idle();
    write_reg(8'd3, 32'hDEAD_BEEF, 1'b0);
    write_reg(8'hFF, 32'h0000_0000, 1'b1);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    // block address wraps past the top
    set_pool(32'hFFFF_FFFF, 16'hFFFF, 7'd64);
    send_cmd(fbpa_pkg::OP_CLEAR, '0);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_ALLOC, '0);
    send_cmd(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);
  endtask

  // one random command: mostly allocate and free of live blocks
  task automatic send_random_cmd();
    int unsigned pick;
    int unsigned n;
    int unsigned sz;
    int unsigned slot;
    int unsigned live[$];
    int unsigned idle[$];
    logic [ADDR_W-1:0] addr;
    n = blocks_active();
    sz = block_bytes();
    for (int unsigned i = 0; i < n; i++) begin
      if (m_taken[i]) live.push_back(i);
      else idle.push_back(i);
    end
    pick = $urandom_range(0, 99);
    if (pick < 40 || (pick < 80 && live.size() == 0)) begin
      send_cmd(fbpa_pkg::OP_ALLOC, $urandom);
    end else if (pick < 80) begin
      slot = live[$urandom_range(0, live.size() - 1)];
      addr = m_base + ADDR_W'(slot) * ADDR_W'(sz) + ADDR_W'($urandom_range(0, sz - 1));
      send_cmd(fbpa_pkg::OP_FREE, addr);
    end else if (pick < 84) begin
      send_cmd(fbpa_pkg::OP_CLEAR, $urandom);
    end else begin
      case ($urandom_range(0, 4))
        0: send_cmd(fbpa_pkg::OP_FREE, $urandom);
        1: send_cmd(fbpa_pkg::OP_FREE, '0);
        2: send_cmd(fbpa_pkg::OP_FREE,
                    (m_base > 1) ? ADDR_W'($urandom_range(1, m_base - 1)) : '0);
        3: send_cmd(fbpa_pkg::OP_NONE, $urandom);
        default: begin
          if (idle.size() != 0)
            slot = idle[$urandom_range(0, idle.size() - 1)];
          else
            slot = $urandom_range(0, POOL_MAX - 1);
          send_cmd(fbpa_pkg::OP_FREE, m_base + ADDR_W'(slot) * ADDR_W'(sz));
        end
      endcase
    end
  endtask

  // random traffic under one register setting and idle rate
  task automatic test_random_traffic(input int unsigned phase, input int unsigned idle_pct);
    logic [SIZE_W-1:0] rnd_size;
    rnd_size = ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'($urandom);
    case (phase)
      0: set_pool($urandom | 32'd1, SIZE_W'($urandom_range(1, 64)), 7'd64);
      1: set_pool(32'd1, 16'd1, CNT_W'($urandom_range(1, 8)));
      2: set_pool($urandom | 32'd1, 16'hFFFF, CNT_W'($urandom_range(1, 64)));
      3: set_pool(32'hFFFF_0000, SIZE_W'($urandom_range(1, 16'hFFFF)), 7'd64);
      4: set_pool(ADDR_W'($urandom_range(1, 32'h00FF_FFFF)), SIZE_W'($urandom_range(1, 4096)),
                  CNT_W'($urandom_range(1, 127)));
      default: set_pool($urandom | 32'd1, rnd_size, CNT_W'($urandom_range(0, 127)));
    endcase
    sender_idle_pct = idle_pct;
    if ($urandom_range(0, 1) == 0) send_cmd(fbpa_pkg::OP_CLEAR, $urandom);
    repeat (PHASE_ITEMS) send_random_cmd();
    wait_idle();
    sender_idle_pct = 0;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    m_base = fbpa_pkg::POOL_BASE_RST;
    m_size = fbpa_pkg::BLOCK_SIZE_RST;
    m_count = fbpa_pkg::BLOCK_COUNT_RST;
    m_taken = '0;
    m_taken_total = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_basic_ops();
    test_register_edges();
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 3)
        0: test_random_traffic(p, 0);
        1: test_random_traffic(p, 67);
        default: test_random_traffic(p, 26);
      endcase
    end

    // drain
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ram.sv
rtl/core/fixed_block_pool_allocator.sv
sim/tb_fixed_block_pool_allocator.sv
